// File: rtl/sfrc_pkg.sv
`timescale 1ns / 1ps

package sfrc_pkg;

   localparam int unsigned BufferLimitDefault = 1024;

   localparam logic [7:0] HeadA = 8'h55;
   localparam logic [7:0] HeadB = 8'hAA;
   localparam logic [16:0] FrameOverhead = 17'd7;

   typedef enum logic [2:0] {
      PH_HEAD_A  = 3'd0,
      PH_HEAD_B  = 3'd1,
      PH_VERSION = 3'd2,
      PH_TYPE    = 3'd3,
      PH_LEN_HI  = 3'd4,
      PH_LEN_LO  = 3'd5,
      PH_BODY    = 3'd6
   } phase_type;

   typedef enum logic [1:0] {
      KIND_PAYLOAD  = 2'd0,
      KIND_GOOD     = 2'd1,
      KIND_BAD      = 2'd2,
      KIND_RESERVED = 2'd3
   } result_kind_type;

   typedef struct packed {
      logic [9:0]      payload_length;
      logic [9:0]      payload_index;
      logic [7:0]      payload_byte;
      logic [7:0]      frame_kind;
      result_kind_type result_kind;
   } result_type;

endpackage

// File: rtl/sfrc_parser.sv
`timescale 1ns / 1ps

module sfrc_parser import sfrc_pkg::*; #(
   parameter int unsigned BUFFER_LIMIT = BufferLimitDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  logic [7:0] rx_byte,
   input  logic [7:0] expected_version,
   output logic       result_valid,
   output result_type result
);

   localparam int unsigned PosW = $clog2(BUFFER_LIMIT);

   phase_type       phase_ff, phase_in;
   logic [PosW-1:0] pos_ff, pos_in;
   logic [15:0]     len_ff, len_in;
   logic [7:0]      sum_ff, sum_in;
   logic [7:0]      kind_ff, kind_in;

   logic [15:0] len_full;
   logic        oversize;
   logic        body_more;
   logic [31:0] pos_wide;

   assign len_full  = {len_ff[15:8], rx_byte};
   assign oversize  = ({1'b0, len_full} + FrameOverhead) >= 17'(BUFFER_LIMIT);
   assign body_more = 16'(pos_ff) < len_ff;
   assign pos_wide  = 32'(pos_ff);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (fire) begin
         case (phase_ff)
            PH_HEAD_A:  if (rx_byte == HeadA) phase_in = PH_HEAD_B;
            PH_HEAD_B:  phase_in = (rx_byte == HeadB) ? PH_VERSION : PH_HEAD_A;
            PH_VERSION: phase_in = (rx_byte == expected_version) ? PH_TYPE : PH_HEAD_A;
            PH_TYPE:    phase_in = PH_LEN_HI;
            PH_LEN_HI:  phase_in = PH_LEN_LO;
            PH_LEN_LO:  phase_in = oversize ? PH_HEAD_A : PH_BODY;
            PH_BODY:    phase_in = body_more ? PH_BODY : PH_HEAD_A;
            default:    phase_in = PH_HEAD_A;
         endcase
      end
   end

   // datapath and result
   always_comb begin
      pos_in  = pos_ff;
      len_in  = len_ff;
      sum_in  = sum_ff;
      kind_in = kind_ff;
      result_valid          = 1'b0;
      result.result_kind    = KIND_PAYLOAD;
      result.frame_kind     = kind_ff;
      result.payload_byte   = 8'd0;
      result.payload_index  = 10'd0;
      result.payload_length = len_ff[9:0];
      if (fire) begin
         case (phase_ff)
            PH_HEAD_A: begin
               if (rx_byte == HeadA) sum_in = HeadA;
            end
            PH_HEAD_B: begin
               if (rx_byte == HeadB) sum_in = sum_ff + rx_byte;
            end
            PH_VERSION: begin
               if (rx_byte == expected_version) sum_in = sum_ff + rx_byte;
            end
            PH_TYPE: begin
               kind_in = rx_byte;
               sum_in  = sum_ff + rx_byte;
            end
            PH_LEN_HI: begin
               len_in = {rx_byte, 8'h00};
               sum_in = sum_ff + rx_byte;
            end
            PH_LEN_LO: begin
               len_in = len_full;
               sum_in = sum_ff + rx_byte;
               pos_in = '0;
            end
            PH_BODY: begin
               result_valid = 1'b1;
               if (body_more) begin
                  sum_in = sum_ff + rx_byte;
                  pos_in = pos_ff + PosW'(1);
                  result.payload_byte  = rx_byte;
                  result.payload_index = pos_wide[9:0];
               end else begin
                  // checksum byte closes the frame
                  pos_in = '0;
                  result.result_kind = (rx_byte == sum_ff) ? KIND_GOOD : KIND_BAD;
               end
            end
            default: begin
               pos_in = pos_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEAD_A;
         pos_ff   <= '0;
         len_ff   <= '0;
         sum_ff   <= '0;
         kind_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         len_ff   <= len_in;
         sum_ff   <= sum_in;
         kind_ff  <= kind_in;
      end
   end

endmodule

// File: rtl/serial_frame_receiver_checksum.sv
`timescale 1ns / 1ps
// A byte passes from the input register through the parser into the result register.
// One byte per cycle unless rsp_tready stalls; parsing is a phase update and 8-bit add.
// A stalled result register holds the input register, which then lowers req_tready.
// Reset (synchronous, active high) clears the parse state, both stage valids and
// expected_version to zero; no clearing pass is needed.
module serial_frame_receiver_checksum import sfrc_pkg::*; #(
   parameter int unsigned BUFFER_LIMIT = BufferLimitDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [7:0] frame_kind, [15:8] payload_byte,
                                    // [25:16] payload_index, [35:26] payload_length, rest 0
   output logic [1:0]  rsp_tuser,   // [1:0] result_kind
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data     // [7:0] expected_version
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;
   logic [7:0] version_ff;

   logic       advance;
   logic       fire;
   logic       res_valid;
   result_type res;

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign fire       = in_valid_ff && advance;
   assign csr_ready  = 1'b1;

   sfrc_parser #(
      .BUFFER_LIMIT(BUFFER_LIMIT)
   ) u_parser (
      .clock            (clock),
      .reset            (reset),
      .fire             (fire),
      .rx_byte          (in_byte_ff),
      .expected_version (version_ff),
      .result_valid     (res_valid),
      .result           (res)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tready) in_valid_in = req_tvalid;
      out_valid_in = out_valid_ff;
      if (advance) out_valid_in = fire && res_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         version_ff   <= 8'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid && csr_ready) version_ff <= csr_data;
      end
   end

   // payload registers: load whenever their stage is ready, valid or not
   always_ff @(posedge clock) begin
      if (req_tready) in_byte_ff <= req_tdata;
      if (advance) out_ff <= res;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.result_kind;
   assign rsp_tdata  = {4'd0, out_ff.payload_length, out_ff.payload_index,
                        out_ff.payload_byte, out_ff.frame_kind};

endmodule
